@@ design/abmh_pkg.sv @@
package abmh_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_CAPACITY  = 1024;
	localparam int DEF_KEY_BITS  = 32;
	localparam int DEF_ITEM_BITS = 32;

	// Field widths on the channels
	localparam int KIND_W   = 3;
	localparam int KEY_W    = 32;
	localparam int ITEM_W   = 32;
	localparam int HANDLE_W = 10;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 11;

	// Operation codes
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DELMIN = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DECKEY = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_FULL        = 3'd1,
		STAT_EMPTY       = 3'd2,
		STAT_BAD_HANDLE  = 3'd3,
		STAT_NOT_SMALLER = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_LOOK,
		S_DISP,
		S_DK_CMP,
		S_RM_B,
		S_RM_C,
		S_SU_RD,
		S_SU_CMP,
		S_SD_L,
		S_SD_R,
		S_SD_C,
		S_PLACE,
		S_FIN
	} state_t;

	// One result beat
	typedef struct packed {
		status_t               status;
		logic [KEY_W-1:0]      out_key;
		logic [ITEM_W-1:0]     out_item;
		logic [HANDLE_W-1:0]   out_handle;
		logic [COUNT_W-1:0]    entry_count;
		logic [KEY_W-1:0]      min_key;
		logic                  min_valid;
	} res_t;

endpackage

@@ design/abmh_in_if.sv @@
interface abmh_in_if import abmh_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [KEY_W-1:0]    key;
	logic [ITEM_W-1:0]   item;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, kind, key, item, handle, input ready);
	modport sink (input valid, kind, key, item, handle, output ready);
endinterface

@@ design/abmh_out_if.sv @@
interface abmh_out_if import abmh_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    out_key;
	logic [ITEM_W-1:0]   out_item;
	logic [HANDLE_W-1:0] out_handle;
	logic [COUNT_W-1:0]  entry_count;
	logic [KEY_W-1:0]    min_key;
	logic                min_valid;

	modport source (output valid, status, out_key, out_item, out_handle, entry_count,
		min_key, min_valid, input ready);
	modport sink (input valid, status, out_key, out_item, out_handle, entry_count,
		min_key, min_valid, output ready);
endinterface

@@ design/addressable_binary_min_heap.sv @@
// Channel | Dir | Beat
// req     | in  | kind, key, item, handle
// rsp     | out | status, out_key, out_item, out_handle, entry_count, min_key, min_valid
//
// One operation at a time; req.ready is high only while the sequencer is idle.
// The single read port of the position-ordered heap memory paces the sequencer: insert
// climbs toward the root; decrease key checks the new key, then climbs; delete moves
// the last entry into the hole, climbs, then sinks; clear sweeps the handle-to-position
// memory. The sequencer returns to idle before the next accept. After reset a sweep
// over all CAPACITY entries zeroes the handle-to-position memory before req.ready
// rises. A result held in the output register while rsp stalls does not block the
// next request; the one after waits in the final state.
module addressable_binary_min_heap import abmh_pkg::*; #(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int KEY_BITS  = DEF_KEY_BITS,
	parameter int ITEM_BITS = DEF_ITEM_BITS
) (
	input logic        clk,
	input logic        arst_n,
	abmh_in_if.sink    req,
	abmh_out_if.source rsp
);

	logic idle, done, ack;
	res_t res, out_q;
	logic out_v_q;

	abmh_core #(
		.CAPACITY  (CAPACITY),
		.KEY_BITS  (KEY_BITS),
		.ITEM_BITS (ITEM_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req.valid && idle),
		.in_kind   (req.kind),
		.in_key    (req.key),
		.in_item   (req.item),
		.in_handle (req.handle),
		.idle      (idle),
		.done      (done),
		.ack       (ack),
		.res       (res)
	);

	assign req.ready = idle;
	assign ack = !out_v_q || rsp.ready;

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (done && ack) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && ack) out_q <= res;
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_q.status;
	assign rsp.out_key     = out_q.out_key;
	assign rsp.out_item    = out_q.out_item;
	assign rsp.out_handle  = out_q.out_handle;
	assign rsp.entry_count = out_q.entry_count;
	assign rsp.min_key     = out_q.min_key;
	assign rsp.min_valid   = out_q.min_valid;

endmodule

@@ design/abmh_core.sv @@
module abmh_core import abmh_pkg::*; #(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int KEY_BITS  = DEF_KEY_BITS,
	parameter int ITEM_BITS = DEF_ITEM_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KIND_W-1:0]   in_kind,
	input  logic [KEY_W-1:0]    in_key,
	input  logic [ITEM_W-1:0]   in_item,
	input  logic [HANDLE_W-1:0] in_handle,
	output logic                idle,
	output logic                done,
	input  logic                ack,
	output res_t                res
);

	localparam int HW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
	localparam logic [PW-1:0] ONE_P = PW'(1);

	typedef struct packed {
		logic [HW-1:0]       h;
		logic [KEY_BITS-1:0] k;
	} ent_t;

	// Storage: heap words by position, item and position by handle, free stack
	ent_t                 heap_mem [CAPACITY];
	logic [ITEM_BITS-1:0] item_mem [CAPACITY];
	logic [PW-1:0]        pos_mem  [CAPACITY];
	logic [HW-1:0]        free_mem [CAPACITY];

	state_t state_q, state_d;

	logic [KIND_W-1:0]    kind_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [ITEM_BITS-1:0] item_q;
	logic [HANDLE_W-1:0]  hin_q;
	logic [PW-1:0]        count_q, fresh_q, fc_q;
	logic [PW-1:0]        p_q, prm_q;
	logic [HW-1:0]        swp_q;
	logic                 rpt_q, down_q, has_item_q;
	ent_t                 cur_q, left_q, rem_q, heap_rd_q;
	logic [PW-1:0]        pos_rd_q;
	logic [HW-1:0]        free_rd_q, oh_q;
	logic [ITEM_BITS-1:0] item_rd_q;
	logic [KEY_BITS-1:0]  okey_q, min_q;
	status_t              st_q;

	// Memory controls
	logic [PW-1:0]        heap_ra, heap_wa;
	logic                 heap_we;
	ent_t                 heap_wd;
	logic                 pos_we;
	logic [HW-1:0]        pos_wa;
	logic [PW-1:0]        pos_wd;
	logic                 item_we, item_re;
	logic                 free_we;

	// Helpers
	logic [PW:0]   l_pos, r_pos;
	logic          has_l, has_r, take_r, sd_move, su_move, used;
	ent_t          child;
	logic [PW-1:0] c_pos;
	logic          ins_ok;
	logic [HW-1:0] ins_h;
	logic [PW-1:0] cnt_dec;

	assign l_pos   = {p_q, 1'b0};
	assign r_pos   = l_pos + 1'b1;
	assign has_l   = l_pos <= {1'b0, count_q};
	assign has_r   = r_pos <= {1'b0, count_q};
	assign take_r  = has_r && !(left_q.k < heap_rd_q.k);
	assign child   = take_r ? heap_rd_q : left_q;
	assign c_pos   = take_r ? PW'(r_pos) : PW'(l_pos);
	assign sd_move = child.k < cur_q.k;
	assign su_move = cur_q.k < heap_rd_q.k;
	assign used    = (32'(hin_q) < 32'(CAPACITY)) && (pos_rd_q != '0);
	assign cnt_dec = count_q - ONE_P;
	assign ins_ok  = (count_q != CAP_P) && ((fc_q != '0) || (fresh_q < CAP_P));
	assign ins_h   = (fc_q != '0) ? free_rd_q : HW'(fresh_q);

	// Next state and memory controls
	always_comb begin
		state_d = state_q;
		heap_ra = p_q >> 1;
		heap_we = 1'b0;
		heap_wa = p_q;
		heap_wd = cur_q;
		pos_we  = 1'b0;
		pos_wa  = cur_q.h;
		pos_wd  = p_q;
		item_we = 1'b0;
		item_re = 1'b0;
		free_we = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_LOOK;
			end
			S_CLR: begin
				pos_we = 1'b1;
				pos_wa = swp_q;
				pos_wd = '0;
				if (swp_q == HW'(CAPACITY - 1)) state_d = rpt_q ? S_FIN : S_IDLE;
			end
			S_LOOK: begin
				state_d = S_DISP;
			end
			S_DISP: begin
				priority case (kind_q)
					KIND_INSERT: begin
						if (ins_ok) begin
							item_we = 1'b1;
							state_d = S_SU_RD;
						end else begin
							state_d = S_FIN;
						end
					end
					KIND_DELMIN: begin
						heap_ra = ONE_P;
						state_d = (count_q == '0) ? S_FIN : S_RM_B;
					end
					KIND_DECKEY: begin
						heap_ra = pos_rd_q;
						state_d = used ? S_DK_CMP : S_FIN;
					end
					KIND_DELETE: begin
						heap_ra = pos_rd_q;
						state_d = used ? S_RM_B : S_FIN;
					end
					KIND_CLEAR: state_d = S_CLR;
					default: state_d = S_FIN;
				endcase
			end
			S_RM_B: begin
				heap_ra = count_q;
				state_d = S_RM_C;
			end
			S_RM_C: begin
				pos_we  = 1'b1;
				pos_wa  = rem_q.h;
				pos_wd  = '0;
				item_re = 1'b1;
				free_we = fc_q < CAP_P;
				state_d = (prm_q <= cnt_dec) ? S_SU_RD : S_FIN;
			end
			S_DK_CMP: begin
				state_d = (key_q > heap_rd_q.k) ? S_FIN : S_SU_RD;
			end
			S_SU_RD: begin
				if (p_q == ONE_P) state_d = down_q ? S_SD_L : S_PLACE;
				else state_d = S_SU_CMP;
			end
			S_SU_CMP: begin
				if (su_move) begin
					heap_we = 1'b1;
					heap_wd = heap_rd_q;
					pos_we  = 1'b1;
					pos_wa  = heap_rd_q.h;
					state_d = S_SU_RD;
				end else begin
					state_d = down_q ? S_SD_L : S_PLACE;
				end
			end
			S_SD_L: begin
				heap_ra = PW'(l_pos);
				state_d = has_l ? S_SD_R : S_PLACE;
			end
			S_SD_R: begin
				heap_ra = PW'(r_pos);
				state_d = S_SD_C;
			end
			S_SD_C: begin
				if (sd_move) begin
					heap_we = 1'b1;
					heap_wd = child;
					pos_we  = 1'b1;
					pos_wa  = child.h;
					state_d = S_SD_L;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (ack) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign idle = state_q == S_IDLE;
	assign done = state_q == S_FIN;

	// Memory ports
	always_ff @(posedge clk) begin
		heap_rd_q <= heap_mem[HW'(heap_ra - ONE_P)];
		if (heap_we) heap_mem[HW'(heap_wa - ONE_P)] <= heap_wd;
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		if (item_we) item_mem[ins_h] <= item_q;
		if (item_re) item_rd_q <= item_mem[rem_q.h];
		if (free_we) free_mem[HW'(fc_q)] <= rem_q.h;
		if (state_q == S_LOOK) begin
			pos_rd_q  <= pos_mem[HW'(hin_q)];
			free_rd_q <= free_mem[HW'(fc_q - ONE_P)];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			count_q <= '0;
			fresh_q <= '0;
			fc_q    <= '0;
			swp_q   <= '0;
			rpt_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLR: swp_q <= swp_q + 1'b1;
				S_DISP: begin
					if (kind_q == KIND_INSERT && ins_ok) begin
						count_q <= count_q + ONE_P;
						if (fc_q != '0) fc_q <= fc_q - ONE_P;
						else fresh_q <= fresh_q + ONE_P;
					end
					if (kind_q == KIND_CLEAR) begin
						count_q <= '0;
						fresh_q <= '0;
						fc_q    <= '0;
						swp_q   <= '0;
						rpt_q   <= 1'b1;
					end
				end
				S_RM_C: begin
					count_q <= cnt_dec;
					if (fc_q < CAP_P) fc_q <= fc_q + ONE_P;
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current operation
	always_ff @(posedge clk) begin
		if (heap_we && heap_wa == ONE_P) min_q <= heap_wd.k;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q     <= in_kind;
					key_q      <= KEY_BITS'(in_key);
					item_q     <= ITEM_BITS'(in_item);
					hin_q      <= in_handle;
					st_q       <= STAT_OK;
					has_item_q <= 1'b0;
					oh_q       <= '0;
					okey_q     <= '0;
				end
			end
			S_DISP: begin
				down_q <= 1'b0;
				priority case (kind_q)
					KIND_INSERT: begin
						if (ins_ok) begin
							cur_q <= '{h: ins_h, k: key_q};
							p_q   <= count_q + ONE_P;
							oh_q  <= ins_h;
						end else begin
							st_q <= STAT_FULL;
						end
					end
					KIND_DELMIN: begin
						prm_q <= ONE_P;
						if (count_q == '0) st_q <= STAT_EMPTY;
					end
					KIND_DECKEY, KIND_DELETE: begin
						prm_q <= pos_rd_q;
						if (!used) st_q <= STAT_BAD_HANDLE;
					end
					default: ;
				endcase
			end
			S_RM_B: rem_q <= heap_rd_q;
			S_RM_C: begin
				okey_q     <= rem_q.k;
				oh_q       <= rem_q.h;
				has_item_q <= 1'b1;
				cur_q      <= heap_rd_q;
				p_q        <= prm_q;
				down_q     <= 1'b1;
			end
			S_DK_CMP: begin
				if (key_q > heap_rd_q.k) st_q <= STAT_NOT_SMALLER;
				cur_q <= '{h: heap_rd_q.h, k: key_q};
				p_q   <= prm_q;
			end
			S_SU_CMP: begin
				if (su_move) p_q <= p_q >> 1;
			end
			S_SD_R: left_q <= heap_rd_q;
			S_SD_C: begin
				if (sd_move) p_q <= c_pos;
			end
			default: ;
		endcase
	end

	// Result of the finished operation
	always_comb begin
		res.status      = st_q;
		res.out_key     = has_item_q ? KEY_W'(okey_q) : '0;
		res.out_item    = has_item_q ? ITEM_W'(item_rd_q) : '0;
		res.out_handle  = HANDLE_W'(oh_q);
		res.entry_count = COUNT_W'(count_q);
		res.min_key     = (count_q != '0) ? KEY_W'(min_q) : '0;
		res.min_valid   = count_q != '0;
	end

endmodule
